@@ hw/rtl/mabs_pkg.sv @@
// shared types, constants and box tags of the mp4 alac box sniffer
package mabs_pkg;

   localparam int unsigned POS_BITS_DEF = 48;
   localparam int unsigned CFG_BITS     = 48;
   localparam int unsigned HCNT_BITS    = 5;

   // header lengths and the stsd preamble
   localparam logic [HCNT_BITS-1:0] HDR_LEN       = 5'd8;
   localparam logic [HCNT_BITS-1:0] EXT_HDR_LEN   = 5'd16;
   localparam logic [HCNT_BITS-1:0] STSD_PREAMBLE = 5'd8;

   // special size words
   localparam logic [31:0] SIZE_TO_END   = 32'd0;
   localparam logic [31:0] SIZE_EXTENDED = 32'd1;

   // level at which sample entries are searched
   localparam logic [2:0] LEVEL_LAST = 3'd6;

   typedef enum logic [1:0] {
      PH_COLLECT = 2'd0,
      PH_SKIP    = 2'd1,
      PH_DONE    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      VERD_SEARCH = 2'd0,
      VERD_FOUND  = 2'd1,
      VERD_FAIL   = 2'd2
   } verdict_type;

   // box name sought at each level
   localparam logic [31:0] BOX_TAGS [8] = '{
      32'h6d6f6f76,  // moov
      32'h7472616b,  // trak
      32'h6d646961,  // mdia
      32'h6d696e66,  // minf
      32'h7374626c,  // stbl
      32'h73747364,  // stsd
      32'h616c6163,  // alac
      32'h616c6163   // alac
   };

   typedef struct packed {
      logic [7:0] byte_value;
      logic       first;
   } item_type;

endpackage

@@ hw/rtl/mabs_chan_if.sv @@
// valid/ready channel interfaces for the request and response sides
interface mabs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       first;

   modport source (output valid, output byte_value, output first, input ready);
   modport sink (input valid, input byte_value, input first, output ready);
endinterface

interface mabs_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink (input valid, input verdict, output ready);
endinterface

@@ hw/rtl/mabs_in_reg.sv @@
// input register stage of the box sniffer
module mabs_in_reg
   import mabs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   mabs_req_if.sink req_if,
   input  logic     out_free,
   output logic     in_valid,
   output item_type in_item
);

   logic     valid_ff;
   item_type item_ff;
   logic     ready;

   assign ready        = !valid_ff || out_free;
   assign req_if.ready = ready;
   assign in_valid     = valid_ff;
   assign in_item      = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && ready) begin
         item_ff <= '{byte_value: req_if.byte_value, first: req_if.first};
      end
   end

endmodule

@@ hw/rtl/mabs_core.sv @@
// box header parse state, next-state logic and response register
module mabs_core
   import mabs_pkg::*;
#(
   parameter int unsigned POS_BITS = POS_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CFG_BITS-1:0] csr_wdata,
   input  logic                in_valid,
   input  item_type            in_item,
   output logic                out_free,
   mabs_rsp_if.source          rsp_if
);

   localparam int unsigned PW = POS_BITS;

   // file length, saturated to the position range
   logic [PW-1:0] flen_ff;
   logic          flen_short_ff;
   logic [PW-1:0] flen_sat;

   logic [2:0]           level_ff, level_in;
   logic [PW-1:0]        position_ff, position_in;
   logic [PW-1:0]        range_end_ff, range_end_in;
   logic [PW-1:0]        box_begin_ff, box_begin_in;
   logic [PW-1:0]        skip_until_ff, skip_until_in;
   logic [63:0]          header_ff, header_in;
   logic [63:0]          ext_size_ff, ext_size_in;
   logic [HCNT_BITS-1:0] header_count_ff, header_count_in;
   phase_type            phase_ff, phase_in;
   verdict_type          result_ff, result_in;

   logic                 rsp_valid_ff;
   verdict_type          verdict_ff;

   logic                 process;
   logic                 start_box;
   logic                 hd_go;
   logic [PW-1:0]        hd_size;
   logic [HCNT_BITS-1:0] hd_hlen;
   logic [PW:0]          box_end;

   assign flen_sat = (|(csr_wdata >> PW)) ? '1 : PW'(csr_wdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff       <= '0;
         flen_short_ff <= 1'b1;
      end else if (csr_we) begin
         flen_ff       <= flen_sat;
         flen_short_ff <= flen_sat < PW'(HDR_LEN);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign process  = in_valid && out_free;

   always_comb begin
      level_in        = level_ff;
      position_in     = position_ff;
      range_end_in    = range_end_ff;
      box_begin_in    = box_begin_ff;
      skip_until_in   = skip_until_ff;
      header_in       = header_ff;
      ext_size_in     = ext_size_ff;
      header_count_in = header_count_ff;
      phase_in        = phase_ff;
      result_in       = result_ff;
      start_box       = 1'b0;
      hd_go           = 1'b0;
      hd_size         = '0;
      hd_hlen         = HDR_LEN;
      box_end         = '0;

      // restart on the first byte of a file
      if (in_item.first) begin
         level_in        = '0;
         position_in     = '0;
         range_end_in    = flen_ff;
         box_begin_in    = '0;
         header_in       = '0;
         ext_size_in     = '0;
         header_count_in = '0;
         phase_in        = PH_COLLECT;
         result_in       = VERD_SEARCH;
         if (flen_short_ff) begin
            result_in = VERD_FAIL;
            phase_in  = PH_DONE;
         end
      end

      if (result_in == VERD_SEARCH) begin
         case (phase_in)
            PH_SKIP: begin
               position_in = position_in + 1'b1;
               if (position_in == skip_until_in) begin
                  start_box = 1'b1;
               end
            end
            PH_COLLECT: begin
               if (header_count_in == '0 &&
                   ({1'b0, position_in} + (PW+1)'(HDR_LEN)) > {1'b0, range_end_in}) begin
                  result_in = VERD_FAIL;
                  phase_in  = PH_DONE;
               end else begin
                  position_in = position_in + 1'b1;
                  if (header_count_in < HDR_LEN) begin
                     header_in       = {header_in[55:0], in_item.byte_value};
                     header_count_in = header_count_in + 1'b1;
                     if (header_count_in == HDR_LEN) begin
                        if (header_in[63:32] == SIZE_EXTENDED) begin
                           if (({1'b0, box_begin_in} + (PW+1)'(EXT_HDR_LEN)) >
                               {1'b0, range_end_in}) begin
                              result_in = VERD_FAIL;
                              phase_in  = PH_DONE;
                           end
                        end else if (header_in[63:32] == SIZE_TO_END) begin
                           hd_go   = 1'b1;
                           hd_size = range_end_in - box_begin_in;
                           hd_hlen = HDR_LEN;
                        end else begin
                           hd_go   = 1'b1;
                           hd_size = PW'(header_in[63:32]);
                           hd_hlen = HDR_LEN;
                        end
                     end
                  end else begin
                     ext_size_in     = {ext_size_in[55:0], in_item.byte_value};
                     header_count_in = header_count_in + 1'b1;
                     if (header_count_in >= EXT_HDR_LEN) begin
                        if (|(ext_size_in >> PW)) begin
                           result_in = VERD_FAIL;
                           phase_in  = PH_DONE;
                        end else begin
                           hd_go   = 1'b1;
                           hd_size = ext_size_in[PW-1:0];
                           hd_hlen = EXT_HDR_LEN;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // complete header: check size, then descend, skip or decide
      if (hd_go) begin
         box_end = {1'b0, box_begin_in} + {1'b0, hd_size};
         if (hd_size < PW'(hd_hlen) || box_end > {1'b0, range_end_in}) begin
            result_in = VERD_FAIL;
            phase_in  = PH_DONE;
         end else if (header_in[31:0] != BOX_TAGS[level_in]) begin
            skip_until_in = box_end[PW-1:0];
            if (position_in == skip_until_in) begin
               start_box = 1'b1;
            end else begin
               phase_in = PH_SKIP;
            end
         end else if (level_in >= LEVEL_LAST) begin
            result_in = VERD_FOUND;
            phase_in  = PH_DONE;
         end else begin
            level_in     = level_in + 1'b1;
            range_end_in = box_end[PW-1:0];
            if (level_in == LEVEL_LAST) begin
               // stsd: room for the version/count word and one entry header
               if (({1'b0, position_in} + (PW+1)'(EXT_HDR_LEN)) > {1'b0, range_end_in}) begin
                  result_in = VERD_FAIL;
                  phase_in  = PH_DONE;
               end else begin
                  skip_until_in = position_in + PW'(STSD_PREAMBLE);
                  phase_in      = PH_SKIP;
               end
            end else begin
               start_box = 1'b1;
            end
         end
      end

      if (start_box) begin
         box_begin_in    = position_in;
         header_count_in = '0;
         header_in       = '0;
         ext_size_in     = '0;
         phase_in        = PH_COLLECT;
         if (({1'b0, position_in} + (PW+1)'(HDR_LEN)) > {1'b0, range_end_in}) begin
            result_in = VERD_FAIL;
            phase_in  = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff        <= '0;
         position_ff     <= '0;
         range_end_ff    <= '0;
         box_begin_ff    <= '0;
         skip_until_ff   <= '0;
         header_ff       <= '0;
         ext_size_ff     <= '0;
         header_count_ff <= '0;
         phase_ff        <= PH_COLLECT;
         result_ff       <= VERD_SEARCH;
      end else if (process) begin
         level_ff        <= level_in;
         position_ff     <= position_in;
         range_end_ff    <= range_end_in;
         box_begin_ff    <= box_begin_in;
         skip_until_ff   <= skip_until_in;
         header_ff       <= header_in;
         ext_size_ff     <= ext_size_in;
         header_count_ff <= header_count_in;
         phase_ff        <= phase_in;
         result_ff       <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         verdict_ff <= result_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.verdict = verdict_ff;

endmodule

@@ hw/rtl/mp4_alac_box_sniffer_unit.sv @@
// top level of the mp4 alac box sniffer
//
// channel   direction  payload                  meaning
// req_if    in         byte_value[7:0], first   one file byte, first marks byte 0
// rsp_if    out        verdict[1:0]             0 searching, 1 alac found, 2 not found
// csr_*     in         csr_wdata[47:0]          file length, sampled at each first byte
//
// the response follows the request transaction through the input register, then
// the header parse logic straight into the response register
// one transaction per cycle sustained while responses are taken; the per-byte parse step is combinational
// synchronous active-high reset clears the parse state, file length reads as zero
// a stalled response holds the output register; the input register then fills
// and req ready drops, so nothing is lost or dropped
module mp4_alac_box_sniffer_unit
   import mabs_pkg::*;
#(
   parameter int unsigned POS_BITS = POS_BITS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   mabs_req_if.sink            req_if,
   mabs_rsp_if.source          rsp_if,
   input  logic                csr_we,
   input  logic [CFG_BITS-1:0] csr_wdata
);

   // handshake between the input register and the parse stage
   logic     out_free;
   logic     in_valid;
   item_type in_item;

   // input register, takes a transaction whenever the parse stage can move
   mabs_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .out_free (out_free),
      .in_valid (in_valid),
      .in_item  (in_item)
   );

   // parse state, file length register and response register
   mabs_core #(
      .POS_BITS (POS_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .out_free  (out_free),
      .rsp_if    (rsp_if)
   );

endmodule

@@ hw/rtl/mabs_checker.sv @@
// port-level checks of the box sniffer and their binding
module mabs_checker
   import mabs_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_verdict
);

   // verdict code never outside its three values
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_verdict == VERD_SEARCH || rsp_verdict == VERD_FOUND ||
                     rsp_verdict == VERD_FAIL))
      else $error("verdict code out of range");

   // reset empties the response register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // request side only stalls behind a blocked response
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked response");

   // stalled response holds its verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_verdict)))
      else $error("stalled response changed");

   // a request offered to an empty pipe is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !rsp_valid) |-> req_ready)
      else $error("request refused with empty response register");

endmodule

bind mp4_alac_box_sniffer_unit mabs_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_verdict (rsp_if.verdict)
);

@@ test/mabs_verdict_checker.sv @@
// verdict checker for the mp4 alac box sniffer: predicts every verdict and compares it
module mabs_verdict_checker
   import mabs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   mabs_req_if                 req_mon,
   mabs_rsp_if                 rsp_mon,
   input  logic                csr_we,
   input  logic [CFG_BITS-1:0] csr_wdata,
   output int                  pending_verdicts,
   output int                  mismatch_count
);

   localparam logic [63:0] OFFSET_MASK = (64'd1 << POS_BITS_DEF) - 64'd1;

   logic [CFG_BITS-1:0]  flen_cfg;
   logic [2:0]           depth;
   logic [63:0]          offset;
   logic [63:0]          range_stop;
   logic [63:0]          box_start;
   logic [63:0]          skip_stop;
   logic [63:0]          hdr_word;
   logic [63:0]          ext_size;
   logic [HCNT_BITS-1:0] hdr_taken;
   phase_type            parse_phase;
   verdict_type          verdict_now;
   verdict_type          verdicts_due[$];
   int                   fail_tally;

   function automatic void clear_parse();
      depth       = '0;
      offset      = '0;
      range_stop  = '0;
      box_start   = '0;
      skip_stop   = '0;
      hdr_word    = '0;
      ext_size    = '0;
      hdr_taken   = '0;
      parse_phase = PH_COLLECT;
      verdict_now = VERD_SEARCH;
   endfunction

   function automatic void conclude(input verdict_type v);
      verdict_now = v;
      parse_phase = PH_DONE;
   endfunction

   // a new box header starts at the current offset
   function automatic void open_box_here();
      box_start   = offset;
      hdr_taken   = '0;
      hdr_word    = '0;
      ext_size    = '0;
      parse_phase = PH_COLLECT;
      if (offset + 64'(HDR_LEN) > range_stop)
         conclude(VERD_FAIL);
   endfunction

   function automatic void skip_ahead(input logic [63:0] stop);
      skip_stop = stop & OFFSET_MASK;
      if (offset == skip_stop)
         open_box_here();
      else
         parse_phase = PH_SKIP;
   endfunction

   function automatic void close_header(input logic [63:0] box_len, input logic [63:0] hlen);
      if (box_len < hlen || box_start + box_len > range_stop) begin
         conclude(VERD_FAIL);
         return;
      end
      if (hdr_word[31:0] != BOX_TAGS[depth]) begin
         skip_ahead(box_start + box_len);
         return;
      end
      if (depth >= LEVEL_LAST) begin
         conclude(VERD_FOUND);
         return;
      end
      depth      = depth + 3'd1;
      range_stop = (box_start + box_len) & OFFSET_MASK;
      if (depth == LEVEL_LAST) begin
         // stsd: version and count word first, then room for one entry header
         if (offset + 64'(STSD_PREAMBLE) + 64'(HDR_LEN) > range_stop)
            conclude(VERD_FAIL);
         else
            skip_ahead(offset + 64'(STSD_PREAMBLE));
      end else begin
         open_box_here();
      end
   endfunction

   function automatic void consume_byte(input logic [7:0] b);
      if (parse_phase == PH_SKIP) begin
         offset = (offset + 64'd1) & OFFSET_MASK;
         if (offset == skip_stop)
            open_box_here();
         return;
      end
      if (parse_phase != PH_COLLECT)
         return;
      if (hdr_taken == '0 && offset + 64'(HDR_LEN) > range_stop) begin
         conclude(VERD_FAIL);
         return;
      end
      offset = (offset + 64'd1) & OFFSET_MASK;
      if (hdr_taken < HDR_LEN) begin
         hdr_word  = {hdr_word[55:0], b};
         hdr_taken = hdr_taken + 1'b1;
         if (hdr_taken == HDR_LEN) begin
            if (hdr_word[63:32] == SIZE_EXTENDED) begin
               if (box_start + 64'(EXT_HDR_LEN) > range_stop)
                  conclude(VERD_FAIL);
            end else if (hdr_word[63:32] == SIZE_TO_END) begin
               close_header(range_stop - box_start, 64'(HDR_LEN));
            end else begin
               close_header({32'd0, hdr_word[63:32]}, 64'(HDR_LEN));
            end
         end
      end else begin
         ext_size  = {ext_size[55:0], b};
         hdr_taken = hdr_taken + 1'b1;
         if (hdr_taken >= EXT_HDR_LEN) begin
            if (ext_size > OFFSET_MASK)
               conclude(VERD_FAIL);
            else
               close_header(ext_size, 64'(EXT_HDR_LEN));
         end
      end
   endfunction

   function automatic verdict_type sniff_byte(input logic [7:0] b, input logic is_first);
      if (is_first) begin
         // a 48-bit length never exceeds the offset range, so no saturation needed
         depth       = '0;
         offset      = '0;
         verdict_now = VERD_SEARCH;
         range_stop  = 64'(flen_cfg);
         open_box_here();
      end
      if (verdict_now == VERD_SEARCH)
         consume_byte(b);
      return verdict_now;
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         clear_parse();
         flen_cfg = '0;
         verdicts_due.delete();
         fail_tally = 0;
      end else begin
         if (csr_we)
            flen_cfg = csr_wdata;
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: verdict %0d with none expected", $time, rsp_mon.verdict);
               fail_tally++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_mon.verdict !== want) begin
                  $display("%0t: verdict mismatch, expected %0d actual %0d",
                           $time, want, rsp_mon.verdict);
                  fail_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            verdicts_due.push_back(sniff_byte(req_mon.byte_value, req_mon.first));
      end
      pending_verdicts <= verdicts_due.size();
      mismatch_count   <= fail_tally;
   end

endmodule

@@ test/tb_mp4_alac_box_sniffer_unit.sv @@
// testbench top for the mp4 alac box sniffer: file stimulus, flow control and verdict
module tb_mp4_alac_box_sniffer_unit;
   import mabs_pkg::*;

   localparam int ITEMS_WANTED = 1450;
   localparam int CYCLE_LIMIT  = 400000;

   // how a generated box writes its size
   typedef enum int {
      FORM_PLAIN  = 0,   // 32-bit size word
      FORM_EXT    = 1,   // size word 1, then a 64-bit size
      FORM_TO_END = 2,   // size word 0, runs to the end of its parent
      FORM_HUGE   = 3    // extended size beyond the offset range
   } hdr_form_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CFG_BITS-1:0] csr_wdata;
   int                  pending_verdicts;
   int                  mismatch_count;

   mabs_req_if req_ch ();
   mabs_rsp_if rsp_ch ();

   // bytes of the file being built, plus the stack of boxes still open
   logic [7:0]   file_q[$];
   int           box_at[8];
   hdr_form_type box_form[8];
   int           open_boxes;
   int           items_sent;
   int           burst_left;

   mp4_alac_box_sniffer_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   mabs_verdict_checker verdict_watch (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_ch),
      .rsp_mon          (rsp_ch),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .pending_verdicts (pending_verdicts),
      .mismatch_count   (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- file builder

   task automatic push_u32(input logic [31:0] w);
      for (int i = 3; i >= 0; i--)
         file_q.push_back(w[i*8 +: 8]);
   endtask

   // header goes in now with a dummy size, patched once the box is closed (a to-end size word stays 0)
   task automatic open_box(input logic [31:0] tag, input hdr_form_type form);
      box_at[open_boxes]   = file_q.size();
      box_form[open_boxes] = form;
      open_boxes++;
      case (form)
         FORM_PLAIN:  push_u32(32'd0);
         FORM_TO_END: push_u32(SIZE_TO_END);
         default:     push_u32(SIZE_EXTENDED);
      endcase
      push_u32(tag);
      if (form == FORM_EXT || form == FORM_HUGE)
         repeat (8) file_q.push_back(8'h00);
   endtask

   task automatic close_box();
      int          at;
      logic [63:0] len;
      open_boxes--;
      at  = box_at[open_boxes];
      len = 64'(file_q.size() - at);
      if (box_form[open_boxes] == FORM_PLAIN) begin
         for (int i = 0; i < 4; i++)
            file_q[at + i] = len[31 - 8*i -: 8];
      end else if (box_form[open_boxes] != FORM_TO_END) begin
         if (box_form[open_boxes] == FORM_HUGE) begin
            // anything with a bit set above the 48-bit range
            len        = {$urandom, $urandom};
            len[63:48] = 16'($urandom_range(1, 65535));
         end
         for (int i = 0; i < 8; i++)
            file_q[at + 8 + i] = len[63 - 8*i -: 8];
      end
   endtask

   // a sibling box with a random name and a short random payload
   task automatic add_filler_box();
      open_box($urandom, ($urandom_range(0, 3) == 0) ? FORM_EXT : FORM_PLAIN);
      repeat ($urandom_range(0, 5)) file_q.push_back(8'($urandom));
      close_box();
   endtask

   function automatic hdr_form_type pick_form();
      int r;
      r = $urandom_range(0, 59);
      if (r < 44)
         return FORM_PLAIN;
      else if (r < 54)
         return FORM_EXT;
      else if (r < 59)
         return FORM_TO_END;
      else
         return FORM_HUGE;
   endfunction

   // mostly a well-formed moov..stsd chain ending in an alac entry, with
   // fillers in between; some files are plain noise, some are corrupted
   task automatic build_file();
      bit bare_stsd;
      int cut;
      file_q.delete();
      open_boxes = 0;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
         return;
      end
      bare_stsd = ($urandom_range(0, 11) == 0);
      for (int lvl = 0; lvl < int'(LEVEL_LAST); lvl++) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) add_filler_box();
         open_box(BOX_TAGS[lvl], pick_form());
      end
      // stsd version and entry count
      repeat (STSD_PREAMBLE) file_q.push_back(8'($urandom));
      // an stsd with no entry at all is too short to hold one
      if (!bare_stsd) begin
         repeat ($urandom_range(0, 2)) add_filler_box();
         open_box(BOX_TAGS[LEVEL_LAST], pick_form());
         repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
      end
      while (open_boxes > 0)
         close_box();
      // a few bytes after the verdict to see it held
      if ($urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 3)) file_q.push_back(8'($urandom));
      if ($urandom_range(0, 4) == 0)
         file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
      if ($urandom_range(0, 7) == 0) begin
         cut    = $urandom_range(1, file_q.size());
         file_q = file_q[0:cut-1];
      end
   endtask

   // ---------------------------------------------------------------- request side

   // one byte per transaction; bursts of random length with random gaps between
   task automatic send_byte(input logic [7:0] val, input logic is_first);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.byte_value <= val;
      req_ch.first      <= is_first;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_file();
      foreach (file_q[i])
         send_byte(file_q[i], i == 0);
   endtask

   // stop offering and wait for every outstanding verdict; the extra edge
   // lets the checker count a transaction taken at this very edge
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_verdicts != 0)
         @(posedge clock);
   endtask

   task automatic write_flen(input logic [CFG_BITS-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      logic [63:0]         wide;
      logic [CFG_BITS-1:0] flen;
      int                  pick;
      int                  files_in_phase;

      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.byte_value <= 8'h00;
      req_ch.first      <= 1'b0;
      items_sent = 0;
      burst_left = 0;
      open_boxes = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // bytes before any first byte: the range is still empty, verdict held after
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      // short range: fewer than a header's worth of bytes in the file
      wait_idle();
      write_flen(48'd3);
      send_byte(8'h5A, 1'b1);

      // size word smaller than its header, with the longest file length
      wait_idle();
      write_flen('1);
      file_q.delete();
      push_u32(32'd4);
      push_u32(BOX_TAGS[0]);
      send_file();

      // extended size far beyond the offset range
      file_q.delete();
      push_u32(SIZE_EXTENDED);
      push_u32(BOX_TAGS[0]);
      push_u32('1);
      push_u32('1);
      send_file();

      // random part: each phase sets a file length while idle, then streams files
      while (items_sent < ITEMS_WANTED) begin
         build_file();
         wait_idle();
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            flen = CFG_BITS'(file_q.size() + $urandom_range(0, 2));
         end else if (pick == 4) begin
            flen = CFG_BITS'(file_q.size() - $urandom_range(1, 8));
         end else if (pick < 7) begin
            flen = '1;
         end else if (pick == 7) begin
            flen = CFG_BITS'($urandom_range(100, 100000));
         end else if (pick == 8) begin
            flen = CFG_BITS'($urandom_range(0, 24));
         end else begin
            wide = {$urandom, $urandom};
            flen = wide[CFG_BITS-1:0];
         end
         write_flen(flen);
         files_in_phase = $urandom_range(1, 4);
         send_file();
         for (int n = 1; n < files_in_phase && items_sent < ITEMS_WANTED; n++) begin
            build_file();
            send_file();
         end
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts == 0)
         $display("tb_mp4_alac_box_sniffer_unit: PASS");
      else
         $display("tb_mp4_alac_box_sniffer_unit: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- response side

   // changing stall pattern, with a long hold-off now and then so that the
   // block fills and backs up into the request side
   initial begin : rsp_side
      int rx_cycle;
      int stretch;
      int mode;
      rx_cycle = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode    = $urandom_range(0, 3);
         stretch = $urandom_range(8, 60);
         repeat (stretch) begin
            @(posedge clock);
            rx_cycle++;
            if (rx_cycle % 2500 == 700) begin
               rsp_ch.ready <= 1'b0;
               repeat (90) @(posedge clock);
               rx_cycle += 90;
            end
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
               2:       rsp_ch.ready <= (rx_cycle % 4 != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
            endcase
         end
      end
   end

   // hang guard
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_mp4_alac_box_sniffer_unit: FAIL");
      $finish;
   end

endmodule
